// ===== hdl/bounded_ordered_list_macros.svh =====
// ---------------------------------------------------------------------------
// bounded_ordered_list_macros
// assertion macros for the ordered list, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_MACROS_SVH
`define BOUNDED_ORDERED_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define BOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BOL_ASSERT_NOW(lbl, ante, cons, msg)
`define BOL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/bol_pkg.sv =====
// ---------------------------------------------------------------------------
// bol_pkg
// shared constants, codes and types of the bounded ordered list
// ---------------------------------------------------------------------------
package bol_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_APPEND,
    OP_DELETE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE,
    STAT_FULL,
    STAT_NOTFOUND,
    STAT_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// ===== hdl/bol_ram.sv =====
// ---------------------------------------------------------------------------
// bol_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bol_seq.sv =====
// ---------------------------------------------------------------------------
// bol_seq
// sequencer: append at tail, search from head and close the gap on delete
// ---------------------------------------------------------------------------
`include "bounded_ordered_list_macros.svh"

module bol_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bol_pkg::op_t                 op,
  input  logic [bol_pkg::KEY_W-1:0]    key,
  input  logic [bol_pkg::CAP_W-1:0]    capacity,
  input  logic                         res_take,
  output logic                         ready,
  output logic                         res_valid,
  output bol_pkg::result_t             res
);

  bol_pkg::seq_state_t state, state_next;
  logic [bol_pkg::IDX_W-1:0] idx, idx_next;
  logic [bol_pkg::CNT_W-1:0] count, count_next;
  logic [bol_pkg::KEY_W-1:0] key_r;
  bol_pkg::status_t          status_r, status_next;

  logic                      ram_we;
  logic [bol_pkg::IDX_W-1:0] ram_waddr;
  logic [bol_pkg::KEY_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [bol_pkg::IDX_W-1:0] ram_raddr;
  logic [bol_pkg::KEY_W-1:0] ram_rdata;

  logic [bol_pkg::CNT_W:0]   idx_ext, cnt_ext, idx_p1, idx_p2;
  logic [bol_pkg::CMP_W-1:0] cap_ext, depth_ext, cap_eff;
  logic                      hit, more1, more2, full;

  assign idx_ext   = (bol_pkg::CNT_W+1)'(idx);
  assign cnt_ext   = (bol_pkg::CNT_W+1)'(count);
  assign idx_p1    = idx_ext + (bol_pkg::CNT_W+1)'(1);
  assign idx_p2    = idx_ext + (bol_pkg::CNT_W+1)'(2);
  assign more1     = idx_p1 < cnt_ext;
  assign more2     = idx_p2 < cnt_ext;
  assign hit       = ram_rdata == key_r;
  assign cap_ext   = bol_pkg::CMP_W'(capacity);
  assign depth_ext = bol_pkg::CMP_W'(bol_pkg::DEPTH);
  assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = bol_pkg::CMP_W'(count) >= cap_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bol_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    status_r <= status_next;
    if (start) begin
      key_r <= key;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bol_pkg::S_IDLE: begin
        if (start) begin
          if (op == bol_pkg::OP_DELETE && count != '0) begin
            state_next = bol_pkg::S_SCAN_RD;
          end else begin
            state_next = bol_pkg::S_FINISH;
          end
        end
      end
      bol_pkg::S_SCAN_RD: begin
        state_next = bol_pkg::S_SCAN_CMP;
      end
      bol_pkg::S_SCAN_CMP: begin
        if (hit && more1) begin
          state_next = bol_pkg::S_SHIFT_RD;
        end else if (!hit && more1) begin
          state_next = bol_pkg::S_SCAN_RD;
        end else begin
          state_next = bol_pkg::S_FINISH;
        end
      end
      bol_pkg::S_SHIFT_RD: begin
        state_next = bol_pkg::S_SHIFT_WR;
      end
      bol_pkg::S_SHIFT_WR: begin
        state_next = more2 ? bol_pkg::S_SHIFT_RD : bol_pkg::S_FINISH;
      end
      bol_pkg::S_FINISH: begin
        if (res_take) begin
          state_next = bol_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bol_pkg::S_IDLE;
      end
    endcase
  end

  // index, count and status
  always_comb begin
    idx_next    = idx;
    count_next  = count;
    status_next = status_r;
    unique case (state)
      bol_pkg::S_IDLE: begin
        if (start) begin
          idx_next = '0;
          if (op == bol_pkg::OP_APPEND) begin
            if (full) begin
              status_next = bol_pkg::STAT_FULL;
            end else begin
              status_next = bol_pkg::STAT_DONE;
              count_next  = count + bol_pkg::CNT_W'(1);
            end
          end else if (count == '0) begin
            status_next = bol_pkg::STAT_EMPTY;
          end else begin
            status_next = bol_pkg::STAT_NOTFOUND;
          end
        end
      end
      bol_pkg::S_SCAN_CMP: begin
        if (hit) begin
          status_next = bol_pkg::STAT_DONE;
          if (!more1) begin
            count_next = count - bol_pkg::CNT_W'(1);
          end
        end else if (more1) begin
          idx_next = bol_pkg::IDX_W'(idx_p1);
        end
      end
      bol_pkg::S_SHIFT_WR: begin
        idx_next = bol_pkg::IDX_W'(idx_p1);
        if (!more2) begin
          count_next = count - bol_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx;
    unique case (state)
      bol_pkg::S_IDLE: begin
        ram_waddr = count[bol_pkg::IDX_W-1:0];
        ram_wdata = key;
        ram_we    = start && op == bol_pkg::OP_APPEND && !full;
      end
      bol_pkg::S_SCAN_RD: begin
        ram_re = 1'b1;
      end
      bol_pkg::S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = bol_pkg::IDX_W'(idx_p1);
      end
      bol_pkg::S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ready      = state == bol_pkg::S_IDLE;
  assign res_valid  = state == bol_pkg::S_FINISH;
  assign res.status = status_r;
  assign res.count  = count;

  bol_ram #(
    .WIDTH (bol_pkg::KEY_W),
    .DEPTH (bol_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `BOL_ASSERT_NOW(a_count_bound, 1'b1, cnt_ext <= (bol_pkg::CNT_W+1)'(bol_pkg::DEPTH), "count above depth")
  `BOL_ASSERT_NOW(a_shift_in_list, state == bol_pkg::S_SHIFT_RD, more1, "shift reads past tail")
  `BOL_ASSERT_NEXT(a_res_held, res_valid && !res_take, res_valid && $stable(res), "result dropped")

endmodule

// ===== hdl/bounded_ordered_list.sv =====
// ---------------------------------------------------------------------------
// bounded_ordered_list
// ordered list of signed keys: append at tail, delete first match by key
// append, full or empty-list delete: from acceptance through S_FINISH to the output register
// delete: entries are read (S_SCAN_RD) and compared (S_SCAN_CMP); after the match, later ones
// are read (S_SHIFT_RD) and written one place down (S_SHIFT_WR), then S_FINISH
// one item at a time: the next word is accepted once the output register has taken the result
// reset: synchronous, clears the list count and sets capacity to 16
// ---------------------------------------------------------------------------
module bounded_ordered_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [31:0]            key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [4:0]                    entry_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [bol_pkg::CAP_W-1:0] capacity;
  logic                      seq_ready, start, res_valid, res_take, cfg_wr;
  bol_pkg::result_t          res;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bol_pkg::REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bol_pkg::CAP_W'(16);
    end else if (cfg_wr && paddr[2] == bol_pkg::REG_CAPACITY) begin
      capacity <= pwdata[bol_pkg::CAP_W-1:0];
    end
  end

  // input word
  assign in_stall = !seq_ready;
  assign start    = in_valid && !in_stall;

  bol_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (bol_pkg::op_t'(op)),
    .key       (bol_pkg::KEY_W'(key)),
    .capacity  (capacity),
    .res_take  (res_take),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status      <= res.status;
      entry_count <= 5'(res.count);
    end
  end

endmodule
